FILE: rtl/core/cle_pkg.sv
// Package: shared types and constants for the circular list engine
`timescale 1ns / 1ps
`default_nettype none
package cle_pkg;
    localparam int POOL_DEPTH = 64;
    localparam int SLOT_W     = $clog2(POOL_DEPTH);
    localparam int LEN_W      = 7;
    localparam int WORD_W     = 32;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_REVERSE = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [LEN_W-1:0]   index;
        logic signed [31:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_res;
        logic [LEN_W-1:0]   length;
    } out_beat_t;

    // datapath operations issued by the controller
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;  // latch input beat
    localparam logic [3:0] OP_RD_TAIL  = 4'd2;  // issue read of link[tail]
    localparam logic [3:0] OP_RD_CUR   = 4'd3;  // issue read of link[cur]
    localparam logic [3:0] OP_STEP     = 4'd4;  // cur <= link read data
    localparam logic [3:0] OP_INSERT   = 4'd5;
    localparam logic [3:0] OP_REMOVE   = 4'd6;
    localparam logic [3:0] OP_REV_STEP = 4'd7;
    localparam logic [3:0] OP_REV_DONE = 4'd8;
    localparam logic [3:0] OP_RD_VAL   = 4'd9;
    localparam logic [3:0] OP_RESULT   = 4'd10;
    localparam logic [3:0] OP_POP      = 4'd11; // read free stack top
    localparam logic [3:0] OP_INS_WR   = 4'd12; // second insert write

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] status;
        logic       take_value;
    } cle_cmd_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [LEN_W-1:0] index;
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] free_count;
        logic [LEN_W-1:0] count;
    } cle_status_t;
endpackage
`default_nettype wire

FILE: rtl/core/circular_list_engine_core.sv
// Top level: circular singly linked list engine
`timescale 1ns / 1ps
`default_nettype none
// One command at a time. A command walks the links one node at a time
// through the link memory: insert walks to the predecessor of the index,
// remove and read to the element at the index, and reverse walks the whole
// list. Rejected commands skip the walk. A stalled result beat holds the
// block. After reset a sweep fills the free stack; commands are held off
// until it ends.
module circular_list_engine_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cle_pkg::in_beat_t s_beat,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cle_pkg::out_beat_t     m_beat
);
    cle_pkg::cle_cmd_t    ctl;
    cle_pkg::cle_status_t sts;
    logic cnt_clr, cnt_inc, rdy;
    logic sweep;

    cle_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid(s_valid & ~sweep), .s_ready(rdy),
        .m_valid, .m_ready, .sts, .ctl, .cnt_clr, .cnt_inc
    );
    assign sweep   = (sts.free_count == '0) && (sts.length == '0);
    assign s_ready = rdy & ~sweep;

    cle_datapath u_dp (
        .aclk, .aresetn, .in_beat(s_beat), .ctl, .cnt_clr, .cnt_inc,
        .sts, .out_beat(m_beat)
    );
endmodule
`default_nettype wire

FILE: rtl/core/cle_datapath.sv
// Datapath: node pool memories, free stack, pointers and result register
`timescale 1ns / 1ps
`default_nettype none
module cle_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cle_pkg::in_beat_t   in_beat,
    input  wire cle_pkg::cle_cmd_t   ctl,
    input  wire logic                cnt_clr,
    input  wire logic                cnt_inc,
    output cle_pkg::cle_status_t     sts,
    output cle_pkg::out_beat_t       out_beat
);
    localparam int SW = cle_pkg::SLOT_W;
    localparam int LW = cle_pkg::LEN_W;

    logic [cle_pkg::WORD_W-1:0] val_mem [cle_pkg::POOL_DEPTH];
    logic [SW-1:0]              link_mem [cle_pkg::POOL_DEPTH];
    logic [SW-1:0]              free_mem [cle_pkg::POOL_DEPTH];

    cle_pkg::in_beat_t  beat_reg;
    logic [SW-1:0]      tail_reg, cur_reg, prev_reg, first_reg, slot_reg;
    logic [SW-1:0]      link_q, free_q;
    logic [cle_pkg::WORD_W-1:0] val_q;
    logic [LW-1:0]      len_reg, free_cnt_reg, cnt_reg;
    logic [LW-1:0]      fill_reg;
    logic               rd_cur;
    logic [SW-1:0]      rd_addr;
    logic [SW-1:0]      free_top;

    assign free_top = SW'(free_cnt_reg - 1'b1);
    // tail read during first step; otherwise current pointer
    assign rd_addr  = (ctl.op == cle_pkg::OP_RD_TAIL) ? tail_reg : cur_reg;
    assign rd_cur   = 1'b1;

    always_ff @(posedge aclk) begin
        if (rd_cur) begin
            link_q <= link_mem[rd_addr];
            val_q  <= val_mem[cur_reg];
        end
        free_q <= free_mem[free_top];
        unique case (ctl.op)
            cle_pkg::OP_INSERT: begin
                val_mem[slot_reg]  <= beat_reg.value;
                link_mem[slot_reg] <= (len_reg == '0) ? slot_reg : link_q;
            end
            cle_pkg::OP_INS_WR: link_mem[cur_reg] <= slot_reg;
            cle_pkg::OP_REMOVE: link_mem[prev_reg] <= link_q;
            cle_pkg::OP_REV_STEP: link_mem[cur_reg] <= prev_reg;
            default: ;
        endcase
        // free stack: reset fill sweep, then push on remove
        if (fill_reg != LW'(cle_pkg::POOL_DEPTH)) begin
            free_mem[fill_reg[SW-1:0]] <= fill_reg[SW-1:0];
        end else if (ctl.op == cle_pkg::OP_REMOVE
                     && free_cnt_reg != LW'(cle_pkg::POOL_DEPTH)) begin
            free_mem[free_cnt_reg[SW-1:0]] <= (len_reg == LW'(1)) ? tail_reg : cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            tail_reg     <= '0;
            len_reg      <= '0;
            free_cnt_reg <= LW'(cle_pkg::POOL_DEPTH);
            cnt_reg      <= '0;
        end else begin
            if (fill_reg != LW'(cle_pkg::POOL_DEPTH)) fill_reg <= fill_reg + 1'b1;
            if (cnt_clr) cnt_reg <= '0;
            else if (cnt_inc) cnt_reg <= cnt_reg + 1'b1;
            unique case (ctl.op)
                cle_pkg::OP_LOAD: beat_reg <= in_beat;
                cle_pkg::OP_RD_TAIL: begin
                    cur_reg  <= tail_reg;
                    prev_reg <= tail_reg;
                end
                cle_pkg::OP_STEP: begin
                    prev_reg <= cur_reg;
                    cur_reg  <= link_q;
                    if (cnt_reg == '0) first_reg <= link_q;
                end
                cle_pkg::OP_POP: slot_reg <= free_q;
                cle_pkg::OP_INSERT: begin
                    free_cnt_reg <= free_cnt_reg - 1'b1;
                    len_reg      <= len_reg + 1'b1;
                    if (len_reg == '0 || LW'(beat_reg.index) == len_reg)
                        tail_reg <= slot_reg;
                end
                cle_pkg::OP_REMOVE: begin
                    if (free_cnt_reg != LW'(cle_pkg::POOL_DEPTH))
                        free_cnt_reg <= free_cnt_reg + 1'b1;
                    len_reg <= len_reg - 1'b1;
                    if (len_reg != LW'(1) && cur_reg == tail_reg) tail_reg <= prev_reg;
                end
                cle_pkg::OP_REV_STEP: begin
                    prev_reg <= cur_reg;
                    cur_reg  <= link_q;
                end
                cle_pkg::OP_REV_DONE: tail_reg <= first_reg;
                cle_pkg::OP_RESULT: begin
                    out_beat.status    <= ctl.status;
                    out_beat.value_res <= ctl.take_value ? val_q : '0;
                    out_beat.length    <= len_reg;
                end
                default: ;
            endcase
        end
    end

    assign sts.cmd            = beat_reg.cmd;
    assign sts.index          = beat_reg.index;
    assign sts.length         = len_reg;
    assign sts.free_count     = (fill_reg != LW'(cle_pkg::POOL_DEPTH)) ? '0 : free_cnt_reg;
    assign sts.count          = cnt_reg;
endmodule
`default_nettype wire

FILE: rtl/core/cle_ctrl.sv
// Controller: command sequencer and handshake for the circular list engine
`timescale 1ns / 1ps
`default_nettype none
module cle_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire cle_pkg::cle_status_t sts,
    output cle_pkg::cle_cmd_t        ctl,
    output logic                     cnt_clr,
    output logic                     cnt_inc
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_TAIL  = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_ACT   = 4'd5;
    localparam logic [3:0] S_ACT2  = 4'd6;
    localparam logic [3:0] S_RVAL  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_POP   = 4'd10;
    localparam logic [3:0] S_REV   = 4'd11;
    localparam logic [3:0] S_RWAIT = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       take_reg, take_next;
    logic [cle_pkg::LEN_W-1:0] steps;

    // insert walks to predecessor (index steps from tail); remove too; read to element
    assign steps = (sts.cmd == cle_pkg::CMD_READ) ? sts.index + 1'b1 : sts.index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= cle_pkg::ST_OK;
            take_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            take_reg   <= take_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        take_next   = take_reg;
        ctl.op      = cle_pkg::OP_NONE;
        ctl.status  = status_reg;
        ctl.take_value = take_reg;
        cnt_clr     = 1'b0;
        cnt_inc     = 1'b0;
        unique case (state_reg)
            S_IDLE: if (s_valid) begin
                ctl.op = cle_pkg::OP_LOAD;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                status_next = cle_pkg::ST_OK;
                take_next   = 1'b0;
                cnt_clr     = 1'b1;
                state_next  = S_TAIL;
                priority if (sts.cmd == cle_pkg::CMD_INSERT) begin
                    if (sts.index > sts.length) begin
                        status_next = cle_pkg::ST_RANGE; state_next = S_DONE;
                    end else if (sts.free_count == '0) begin
                        status_next = cle_pkg::ST_FULL; state_next = S_DONE;
                    end
                end else if (sts.length == '0) begin
                    status_next = cle_pkg::ST_EMPTY; state_next = S_DONE;
                end else if (sts.cmd != cle_pkg::CMD_REVERSE && sts.index >= sts.length) begin
                    status_next = cle_pkg::ST_RANGE; state_next = S_DONE;
                end
            end
            S_TAIL: begin
                ctl.op = cle_pkg::OP_RD_TAIL;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                // link_q valid for cur_reg this cycle
                if (sts.cmd == cle_pkg::CMD_REVERSE) begin
                    ctl.op = cle_pkg::OP_STEP;  // cur <= first, prev <= tail
                    state_next = S_RWAIT;
                end else if (sts.count == steps) begin
                    if (sts.cmd == cle_pkg::CMD_REMOVE) begin
                        ctl.op = cle_pkg::OP_STEP;  // prev <= pred, cur <= victim
                        cnt_inc = 1'b1;
                        state_next = S_ACT;
                    end else begin
                        state_next = (sts.cmd == cle_pkg::CMD_INSERT) ? S_POP : S_RVAL;
                    end
                end else begin
                    ctl.op = cle_pkg::OP_STEP;
                    cnt_inc = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (sts.cmd == cle_pkg::CMD_REMOVE && sts.count == steps + 1'b1) begin
                    ctl.op = cle_pkg::OP_REMOVE;
                    state_next = S_DONE;
                end else begin
                    ctl.op = cle_pkg::OP_RD_CUR;
                    state_next = S_WAIT;
                end
            end
            S_ACT: begin
                ctl.op = cle_pkg::OP_RD_CUR;  // fetch victim successor
                state_next = S_WALK;
            end
            S_POP: begin
                ctl.op = cle_pkg::OP_POP;
                state_next = S_ACT2;
            end
            S_ACT2: begin
                ctl.op = cle_pkg::OP_INSERT;
                state_next = (sts.length == '0) ? S_DONE : S_REV;
            end
            S_REV: begin
                ctl.op = cle_pkg::OP_INS_WR;
                state_next = S_DONE;
            end
            S_RWAIT: begin
                if (sts.count == sts.length) begin
                    ctl.op = cle_pkg::OP_REV_DONE;
                    state_next = S_DONE;
                end else begin
                    ctl.op = cle_pkg::OP_RD_CUR;
                    state_next = S_RVAL;
                end
            end
            S_RVAL: begin
                if (sts.cmd == cle_pkg::CMD_REVERSE) begin
                    ctl.op = cle_pkg::OP_REV_STEP;
                    cnt_inc = 1'b1;
                    state_next = S_RWAIT;
                end else begin
                    take_next = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                ctl.op = cle_pkg::OP_RESULT;
                state_next = S_OUT;
            end
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/core/cle_checker.sv
// Checker: port-level assertions for the circular list engine
`timescale 1ns / 1ps
`default_nettype none
module cle_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire cle_pkg::out_beat_t m_beat
);
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_beat.length <= cle_pkg::LEN_W'(cle_pkg::POOL_DEPTH))
        else $error("length over pool");
    a_val: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_beat.status != cle_pkg::ST_OK |-> m_beat.value_res == '0)
        else $error("value on error");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("overlap");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("second beat while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_beat)) else $error("drop");
endmodule
bind circular_list_engine_core cle_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_beat
);
`default_nettype wire
